// ----- rtl/dpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual pool page allocator package
// Shared request and response types, field codes, flag layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dpa_pkg;

   localparam int PAGES_W = 11;
   localparam int ADDR_W  = 32;
   localparam int FLAGS_W = 2;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam int TAKEN_BIT = 0;
   localparam int LAST_BIT  = 1;

   localparam int SMALL_SHIFT = 8;
   localparam int LARGE_SHIFT = 12;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic POOL_SMALL = 1'b0;
   localparam logic POOL_LARGE = 1'b1;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_REJECT  = 2'd2;

   localparam logic [1:0] REG_SMALL_PAGES = 2'd0;
   localparam logic [1:0] REG_LARGE_PAGES = 2'd1;
   localparam logic [1:0] REG_SMALL_BASE  = 2'd2;
   localparam logic [1:0] REG_LARGE_BASE  = 2'd3;

   typedef struct packed {
      logic               op;
      logic               pool;
      logic [PAGES_W-1:0] page_count;
      logic [ADDR_W-1:0]  address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic       clr_step;
      logic       load_req;
      logic       decode;
      logic       scan;
      logic       mark;
      logic       free_ck;
      logic       load_rsp;
      logic [1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic op;
      logic ok;
      logic found;
      logic exhausted;
      logic mark_last;
      logic free_end;
      logic free_taken;
      logic free_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/dpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dpa_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/dpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual pool page allocator controller
// Sequences the clearing pass, request decode, first-fit scan, run marking,
// free walk and response hand-off.
// ----------------------------------------------------------------------------
module dpa_ctrl
   import dpa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DECODE  = 3'd2;
   localparam logic [2:0] S_SCAN    = 3'd3;
   localparam logic [2:0] S_MARK    = 3'd4;
   localparam logic [2:0] S_FREE_RD = 3'd5;
   localparam logic [2:0] S_FREE_CK = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] code_ff;
   logic [1:0] code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (!sts.ok) begin
               code_in  = ST_REJECT;
               state_in = S_DONE;
            end else if (sts.op == OP_FREE) begin
               state_in = S_FREE_RD;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.found) begin
               state_in = S_MARK;
            end else if (sts.exhausted) begin
               code_in  = ST_NOSPACE;
               state_in = S_DONE;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            if (sts.mark_last) begin
               code_in  = ST_DONE;
               state_in = S_DONE;
            end
         end
         S_FREE_RD: begin
            if (sts.free_end) begin
               code_in  = ST_DONE;
               state_in = S_DONE;
            end else begin
               state_in = S_FREE_CK;
            end
         end
         S_FREE_CK: begin
            cmd.free_ck = 1'b1;
            if (!sts.free_taken || sts.free_last) begin
               code_in  = ST_DONE;
               state_in = S_DONE;
            end else begin
               state_in = S_FREE_RD;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = code_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/dpa_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual pool page allocator datapath
// Holds the request, the page flag memories, the scan and walk counters and
// the response register.
// ----------------------------------------------------------------------------
module dpa_dpath
   import dpa_pkg::*;
#(
   parameter int SMALL_PAGES_MAX = 1024,
   parameter int LARGE_PAGES_MAX = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_data,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [PAGES_W-1:0] small_pages,
   input  wire logic [PAGES_W-1:0] large_pages,
   input  wire logic [ADDR_W-1:0]  small_base,
   input  wire logic [ADDR_W-1:0]  large_base,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data
);

   localparam int PMAX   = (SMALL_PAGES_MAX > LARGE_PAGES_MAX) ? SMALL_PAGES_MAX
                                                               : LARGE_PAGES_MAX;
   localparam int FULL_W = $clog2(PMAX + 1);
   localparam int CW     = (FULL_W < PAGES_W) ? FULL_W : PAGES_W;
   localparam int CLW    = $clog2(PMAX);
   localparam int SAW    = $clog2(SMALL_PAGES_MAX);
   localparam int LAW    = $clog2(LARGE_PAGES_MAX);

   logic               op_ff;
   logic               pool_ff;
   logic [PAGES_W-1:0] want_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [CW-1:0]      cnt_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      pidx_ff;
   logic               pend_ff;
   logic [CW-1:0]      run_ff;
   logic [CW-1:0]      start_ff;
   logic [CW-1:0]      end_ff;
   logic [CW-1:0]      mark_ff;
   logic [CLW-1:0]     clr_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [CW-1:0]      cnt_small;
   logic [CW-1:0]      cnt_large;
   logic [FLAGS_W-1:0] s_rd_data;
   logic [FLAGS_W-1:0] l_rd_data;
   logic [FLAGS_W-1:0] rd_flags;
   logic               taken;
   logic               last;
   logic [CW-1:0]      run_inc;
   logic               found;
   logic               issue;
   logic [ADDR_W-1:0]  off;
   logic [23:0]        page_off;
   logic               free_ok;
   logic               alloc_ok;
   logic [CW-1:0]      start_calc;
   logic [CW-1:0]      wr_idx;
   logic [FLAGS_W-1:0] wr_flags;
   logic               write;
   logic               s_we;
   logic               l_we;
   logic [SAW-1:0]     s_waddr;
   logic [LAW-1:0]     l_waddr;
   logic [FLAGS_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  blk_addr;

   assign cnt_small = (32'(small_pages) > 32'(SMALL_PAGES_MAX)) ? CW'(SMALL_PAGES_MAX)
                                                                : CW'(small_pages);
   assign cnt_large = (32'(large_pages) > 32'(LARGE_PAGES_MAX)) ? CW'(LARGE_PAGES_MAX)
                                                                : CW'(large_pages);

   assign rd_flags = (pool_ff == POOL_LARGE) ? l_rd_data : s_rd_data;
   assign taken    = rd_flags[TAKEN_BIT];
   assign last     = rd_flags[LAST_BIT];

   assign run_inc    = run_ff + 1'b1;
   assign found      = pend_ff && !taken && (32'(run_inc) == 32'(want_ff));
   assign issue      = (idx_ff < cnt_ff);
   assign start_calc = CW'(32'(pidx_ff) + 32'd1 - 32'(want_ff));

   assign off      = addr_ff - base_ff;
   assign page_off = (pool_ff == POOL_LARGE) ? 24'(off >> LARGE_SHIFT)
                                             : 24'(off >> SMALL_SHIFT);
   assign free_ok  = (addr_ff != '0) && (addr_ff >= base_ff) && (page_off < 24'(cnt_ff));
   assign alloc_ok = (want_ff != '0) && (32'(want_ff) <= 32'(cnt_ff));

   always_comb begin
      wr_flags = '0;
      if (cmd.mark) begin
         wr_flags[TAKEN_BIT] = 1'b1;
         wr_flags[LAST_BIT]  = (mark_ff == end_ff);
      end
   end

   assign wr_idx    = cmd.mark ? mark_ff : idx_ff;
   assign write     = cmd.mark || (cmd.free_ck && taken);
   assign mem_wdata = cmd.clr_step ? '0 : wr_flags;
   assign s_we      = cmd.clr_step ? (32'(clr_ff) < 32'(SMALL_PAGES_MAX))
                                   : (write && (pool_ff == POOL_SMALL));
   assign l_we      = cmd.clr_step ? (32'(clr_ff) < 32'(LARGE_PAGES_MAX))
                                   : (write && (pool_ff == POOL_LARGE));
   assign s_waddr   = cmd.clr_step ? SAW'(clr_ff) : SAW'(wr_idx);
   assign l_waddr   = cmd.clr_step ? LAW'(clr_ff) : LAW'(wr_idx);

   dpa_ram #(
      .WIDTH(FLAGS_W),
      .DEPTH(SMALL_PAGES_MAX)
   ) u_small_flags (
      .clock  (clock),
      .wr_en  (s_we),
      .wr_addr(s_waddr),
      .wr_data(mem_wdata),
      .rd_addr(SAW'(idx_ff)),
      .rd_data(s_rd_data)
   );

   dpa_ram #(
      .WIDTH(FLAGS_W),
      .DEPTH(LARGE_PAGES_MAX)
   ) u_large_flags (
      .clock  (clock),
      .wr_en  (l_we),
      .wr_addr(l_waddr),
      .wr_data(mem_wdata),
      .rd_addr(LAW'(idx_ff)),
      .rd_data(l_rd_data)
   );

   assign blk_addr = (pool_ff == POOL_LARGE) ? (base_ff + (32'(start_ff) << LARGE_SHIFT))
                                             : (base_ff + (32'(start_ff) << SMALL_SHIFT));

   always_comb begin
      sts            = '0;
      sts.clr_done   = (32'(clr_ff) == PMAX - 1);
      sts.op         = op_ff;
      sts.ok         = (op_ff == OP_FREE) ? free_ok : alloc_ok;
      sts.found      = found;
      sts.exhausted  = !found && !issue;
      sts.mark_last  = (mark_ff == end_ff);
      sts.free_end   = !issue;
      sts.free_taken = taken;
      sts.free_last  = last;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.decode) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan) begin
            pend_ff <= !found && issue;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_data.op;
         pool_ff <= req_data.pool;
         want_ff <= req_data.page_count;
         addr_ff <= req_data.address;
         cnt_ff  <= (req_data.pool == POOL_LARGE) ? cnt_large : cnt_small;
         base_ff <= (req_data.pool == POOL_LARGE) ? large_base : small_base;
      end
      if (cmd.decode) begin
         run_ff <= '0;
         idx_ff <= (op_ff == OP_FREE) ? CW'(page_off) : '0;
      end
      if (cmd.scan) begin
         if (pend_ff) begin
            run_ff <= taken ? '0 : run_inc;
         end
         if (found) begin
            start_ff <= start_calc;
            mark_ff  <= start_calc;
            end_ff   <= pidx_ff;
         end else if (issue) begin
            idx_ff  <= idx_ff + 1'b1;
            pidx_ff <= idx_ff;
         end
      end
      if (cmd.mark) begin
         mark_ff <= mark_ff + 1'b1;
      end
      if (cmd.free_ck && taken) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.status        <= cmd.rsp_status;
         rsp_data_ff.block_address <= ((cmd.rsp_status == ST_DONE) && (op_ff == OP_ALLOC))
                                      ? blk_addr : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_mark_in_pool: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> (mark_ff < cnt_ff))
      else $error("Run marking left the pool.");

   a_one_pool_write: assert property (@(posedge clock) disable iff (reset)
      !cmd.clr_step |-> !(s_we && l_we))
      else $error("Both flag memories written by one request.");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("Response register not loaded.");

   a_free_in_pool: assert property (@(posedge clock) disable iff (reset)
      (cmd.free_ck && taken) |-> (idx_ff < cnt_ff))
      else $error("Free walk cleared a page outside the pool.");
`endif

endmodule
`default_nettype wire

// ----- rtl/dual_pool_page_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual pool page allocator
// First-fit contiguous page allocator over a pool of 256-byte pages and a
// pool of 4 KiB pages, with an APB-style register port.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_data (req_type)
//   rsp_      out        rsp_valid / rsp_stall   rsp_data (rsp_type)
//   csr_      in/out     psel, penable, pready   paddr, pwdata, prdata
//
// After reset both flag memories are cleared one entry per cycle, and no request
// is taken until the clearing pass is done. An allocate scans the pool memory
// through its single read port, then marks the pages of the run; a free reads
// and checks each page in turn until a page that is not taken, the last page of
// the run or the end of the pool. A rejected request goes straight to the response.
// The controller returns to idle between requests, and a response held by rsp_stall
// delays the next request only once the request after it has finished.
// ----------------------------------------------------------------------------
module dual_pool_page_allocator_top
   import dpa_pkg::*;
#(
   parameter int SMALL_PAGES_MAX = 1024,
   parameter int LARGE_PAGES_MAX = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   logic [PAGES_W-1:0] small_pages_ff;
   logic [PAGES_W-1:0] large_pages_ff;
   logic [ADDR_W-1:0]  small_base_ff;
   logic [ADDR_W-1:0]  large_base_ff;
   logic               csr_wr;
   cmd_type            cmd;
   sts_type            sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         small_pages_ff <= '0;
         large_pages_ff <= '0;
         small_base_ff  <= '0;
         large_base_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_SMALL_PAGES: small_pages_ff <= csr_pwdata[PAGES_W-1:0];
            REG_LARGE_PAGES: large_pages_ff <= csr_pwdata[PAGES_W-1:0];
            REG_SMALL_BASE:  small_base_ff  <= csr_pwdata;
            REG_LARGE_BASE:  large_base_ff  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SMALL_PAGES: csr_prdata = CSR_DW'(small_pages_ff);
         REG_LARGE_PAGES: csr_prdata = CSR_DW'(large_pages_ff);
         REG_SMALL_BASE:  csr_prdata = small_base_ff;
         REG_LARGE_BASE:  csr_prdata = large_base_ff;
         default:         csr_prdata = '0;
      endcase
   end

   dpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   dpa_dpath #(
      .SMALL_PAGES_MAX(SMALL_PAGES_MAX),
      .LARGE_PAGES_MAX(LARGE_PAGES_MAX)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .small_pages(small_pages_ff),
      .large_pages(large_pages_ff),
      .small_base (small_base_ff),
      .large_base (large_base_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
